// ===== design/shp_pkg.sv =====
// Shared types, codes and byte helpers for the SOCKS5 handshake parser.
// No dependencies; every other design file refers to it by scoped names.
package shp_pkg;

    // Parser phases
    typedef enum logic [3:0] {
        PH_GVER   = 4'd0,
        PH_GNMETH = 4'd1,
        PH_GMETH  = 4'd2,
        PH_RVER   = 4'd3,
        PH_RCMD   = 4'd4,
        PH_RRSV   = 4'd5,
        PH_RATYP  = 4'd6,
        PH_RLEN   = 4'd7,
        PH_RADDR  = 4'd8,
        PH_PHI    = 4'd9,
        PH_PLO    = 4'd10,
        PH_DONE   = 4'd11
    } phase_t;

    // Kind of result burst queued for the emitter
    typedef enum logic [1:0] {
        BURST_ERR   = 2'd0,
        BURST_GREET = 2'd1,
        BURST_ADDR  = 2'd2,
        BURST_FINAL = 2'd3
    } burst_t;

    // out_kind codes
    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_ADDR  = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    // error_code values
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_VER   = 2'd1;
    localparam logic [1:0] ERR_BAD_ATYP  = 2'd2;
    localparam logic [1:0] ERR_ZERO_NAME = 2'd3;

    // Protocol constants
    localparam logic [7:0] SOCKS_VER  = 8'h05;
    localparam logic [7:0] ATYP_IPV4  = 8'h01;
    localparam logic [7:0] ATYP_NAME  = 8'h03;
    localparam logic [7:0] IPV4_BYTES = 8'd4;

    // Beat indexes inside a burst
    localparam logic [3:0] GREET_LAST_BEAT = 4'd1;
    localparam logic [3:0] FINAL_LAST_BEAT = 4'd9;

    // One queued burst
    typedef struct packed {
        burst_t      burst;
        logic [7:0]  addr_byte;
        logic [1:0]  err_code;
        logic [15:0] port;
        logic        addr_kind;
    } burst_desc_t;

    function automatic logic [7:0] nib_swap(input logic [7:0] b);
        nib_swap = {b[3:0], b[7:4]};
    endfunction

    function automatic logic [7:0] wire_byte(input logic [7:0] b, input logic en);
        wire_byte = en ? nib_swap(b) : b;
    endfunction

    // Greeting reply 05 00
    function automatic logic [7:0] greet_reply(input logic idx);
        greet_reply = idx ? 8'h00 : SOCKS_VER;
    endfunction

    // Fixed head of the final reply; the port follows it
    function automatic logic [7:0] final_reply(input logic [2:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd0:    r = 8'h05;
            3'd1:    r = 8'h00;
            3'd2:    r = 8'h00;
            3'd3:    r = 8'h01;
            3'd4:    r = 8'h34;
            3'd5:    r = 8'h45;
            3'd6:    r = 8'hF2;
            3'd7:    r = 8'h5E;
            default: r = 8'h00;
        endcase
        final_reply = r;
    endfunction

endpackage

// ===== design/shp_parser.sv =====
// Byte parser: phase machine plus a one-entry result register holding a burst.
// Depends on shp_pkg.
module shp_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 swap_en,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           rx_byte,
    input  logic                 new_session,
    input  logic                 load_ready,   // emitter can take a burst this cycle
    output logic                 pend_valid,
    output shp_pkg::burst_desc_t pend_desc
);

    shp_pkg::phase_t      phase_reg, phase_next;
    logic [7:0]           remaining_reg, remaining_next;
    logic                 ver_ok_reg, ver_ok_next;
    logic                 atype_reg, atype_next;
    logic [7:0]           port_hi_reg, port_hi_next;
    logic                 pend_valid_reg, pend_valid_next;
    shp_pkg::burst_desc_t pend_reg, pend_next;

    shp_pkg::phase_t      cur_phase;
    logic [7:0]           b;
    logic [7:0]           rem_dec;
    logic                 accept;
    logic                 pop;
    logic                 push;
    shp_pkg::burst_desc_t desc;

    assign pop      = pend_valid_reg && load_ready;
    assign in_ready = !pend_valid_reg || pop;
    assign accept   = in_valid && in_ready;

    // new_session restarts at the greeting before the byte is parsed
    assign cur_phase = new_session ? shp_pkg::PH_GVER : phase_reg;
    assign b         = shp_pkg::wire_byte(rx_byte, swap_en);
    assign rem_dec   = remaining_reg - 8'd1;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (cur_phase)
                shp_pkg::PH_GVER:   phase_next = shp_pkg::PH_GNMETH;
                shp_pkg::PH_GNMETH: phase_next = shp_pkg::PH_GMETH;
                shp_pkg::PH_GMETH:
                begin
                    if (rem_dec == 8'd0)
                        phase_next = ver_ok_reg ? shp_pkg::PH_RVER : shp_pkg::PH_DONE;
                end
                shp_pkg::PH_RVER:   phase_next = shp_pkg::PH_RCMD;
                shp_pkg::PH_RCMD:   phase_next = shp_pkg::PH_RRSV;
                shp_pkg::PH_RRSV:   phase_next = shp_pkg::PH_RATYP;
                shp_pkg::PH_RATYP:
                begin
                    if (b == shp_pkg::ATYP_IPV4)
                        phase_next = shp_pkg::PH_RADDR;
                    else if (b == shp_pkg::ATYP_NAME)
                        phase_next = shp_pkg::PH_RLEN;
                    else
                        phase_next = shp_pkg::PH_DONE;
                end
                shp_pkg::PH_RLEN:
                    phase_next = (b == 8'd0) ? shp_pkg::PH_DONE : shp_pkg::PH_RADDR;
                shp_pkg::PH_RADDR:
                begin
                    if (rem_dec == 8'd0)
                        phase_next = shp_pkg::PH_PHI;
                end
                shp_pkg::PH_PHI:    phase_next = shp_pkg::PH_PLO;
                shp_pkg::PH_PLO:    phase_next = shp_pkg::PH_DONE;
                default:            phase_next = shp_pkg::PH_DONE;
            endcase
        end
    end

    // Datapath registers and the burst produced by this byte
    always_comb
    begin
        remaining_next  = remaining_reg;
        ver_ok_next     = ver_ok_reg;
        atype_next      = atype_reg;
        port_hi_next    = port_hi_reg;
        push            = 1'b0;
        desc.burst      = shp_pkg::BURST_ERR;
        desc.addr_byte  = 8'd0;
        desc.err_code   = shp_pkg::ERR_NONE;
        desc.port       = 16'd0;
        desc.addr_kind  = 1'b0;
        if (accept)
        begin
            unique case (cur_phase)
                shp_pkg::PH_GVER:
                    ver_ok_next = (b == shp_pkg::SOCKS_VER);
                shp_pkg::PH_GNMETH:
                    remaining_next = (b == 8'd0) ? 8'd1 : b;
                shp_pkg::PH_GMETH:
                begin
                    remaining_next = rem_dec;
                    if (rem_dec == 8'd0)
                    begin
                        push = 1'b1;
                        if (ver_ok_reg)
                            desc.burst = shp_pkg::BURST_GREET;
                        else
                            desc.err_code = shp_pkg::ERR_BAD_VER;
                    end
                end
                shp_pkg::PH_RATYP:
                begin
                    if (b == shp_pkg::ATYP_IPV4)
                    begin
                        atype_next     = 1'b0;
                        remaining_next = shp_pkg::IPV4_BYTES;
                    end
                    else if (b == shp_pkg::ATYP_NAME)
                        atype_next = 1'b1;
                    else
                    begin
                        push          = 1'b1;
                        desc.err_code = shp_pkg::ERR_BAD_ATYP;
                    end
                end
                shp_pkg::PH_RLEN:
                begin
                    if (b == 8'd0)
                    begin
                        push          = 1'b1;
                        desc.err_code = shp_pkg::ERR_ZERO_NAME;
                    end
                    else
                        remaining_next = b;
                end
                shp_pkg::PH_RADDR:
                begin
                    remaining_next = rem_dec;
                    push           = 1'b1;
                    desc.burst     = shp_pkg::BURST_ADDR;
                    desc.addr_byte = b;
                    desc.addr_kind = atype_reg;
                end
                shp_pkg::PH_PHI:
                    port_hi_next = b;
                shp_pkg::PH_PLO:
                begin
                    push           = 1'b1;
                    desc.burst     = shp_pkg::BURST_FINAL;
                    desc.port      = {port_hi_reg, b};
                    desc.addr_kind = atype_reg;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    // Result register: filled by a byte that yields results, drained by the emitter
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (push)
        begin
            pend_valid_next = 1'b1;
            pend_next       = desc;
        end
        else if (pop)
            pend_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= shp_pkg::PH_GVER;
            remaining_reg  <= 8'd0;
            ver_ok_reg     <= 1'b0;
            atype_reg      <= 1'b0;
            port_hi_reg    <= 8'd0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            remaining_reg  <= remaining_next;
            ver_ok_reg     <= ver_ok_next;
            atype_reg      <= atype_next;
            port_hi_reg    <= port_hi_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    assign pend_valid = pend_valid_reg;
    assign pend_desc  = pend_reg;

endmodule

// ===== design/shp_emitter.sv =====
// Output sequencer: holds one burst and plays it out one beat per cycle while out_ready is high.
// Depends on shp_pkg.
module shp_emitter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 swap_en,
    input  logic                 pend_valid,
    input  shp_pkg::burst_desc_t pend_desc,
    output logic                 load_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           out_kind,
    output logic [7:0]           out_byte,
    output logic [15:0]          dest_port,
    output logic                 addr_kind,
    output logic [1:0]           error_code,
    output logic                 out_last
);

    logic                 valid_reg, valid_next;
    logic [3:0]           beat_reg, beat_next;
    shp_pkg::burst_desc_t desc_reg, desc_next;

    logic                 last_beat;
    logic                 beat_done;
    logic                 load;

    always_comb
    begin
        unique case (desc_reg.burst)
            shp_pkg::BURST_GREET: last_beat = (beat_reg == shp_pkg::GREET_LAST_BEAT);
            shp_pkg::BURST_FINAL: last_beat = (beat_reg == shp_pkg::FINAL_LAST_BEAT);
            default:              last_beat = 1'b1;
        endcase
    end

    assign beat_done  = valid_reg && out_ready;
    assign load_ready = !valid_reg || (out_ready && last_beat);
    assign load       = pend_valid && load_ready;

    always_comb
    begin
        valid_next = valid_reg;
        beat_next  = beat_reg;
        desc_next  = desc_reg;
        if (load)
        begin
            valid_next = 1'b1;
            beat_next  = 4'd0;
            desc_next  = pend_desc;
        end
        else if (beat_done)
        begin
            if (last_beat)
                valid_next = 1'b0;
            else
                beat_next = beat_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            beat_reg  <= 4'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            beat_reg  <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

    // Beat contents
    always_comb
    begin
        out_kind   = shp_pkg::KIND_REPLY;
        out_byte   = 8'd0;
        dest_port  = 16'd0;
        addr_kind  = 1'b0;
        error_code = shp_pkg::ERR_NONE;
        unique case (desc_reg.burst)
            shp_pkg::BURST_ERR:
            begin
                out_kind   = shp_pkg::KIND_ERR;
                error_code = desc_reg.err_code;
            end
            shp_pkg::BURST_GREET:
                out_byte = shp_pkg::wire_byte(shp_pkg::greet_reply(beat_reg[0]), swap_en);
            shp_pkg::BURST_ADDR:
            begin
                out_kind  = shp_pkg::KIND_ADDR;
                out_byte  = desc_reg.addr_byte;
                addr_kind = desc_reg.addr_kind;
            end
            shp_pkg::BURST_FINAL:
            begin
                dest_port = desc_reg.port;
                addr_kind = desc_reg.addr_kind;
                if (!beat_reg[3])
                    out_byte = shp_pkg::wire_byte(shp_pkg::final_reply(beat_reg[2:0]),
                                                  swap_en);
                else if (!beat_reg[0])
                    out_byte = shp_pkg::wire_byte(desc_reg.port[15:8], swap_en);
                else
                    out_byte = shp_pkg::wire_byte(desc_reg.port[7:0], swap_en);
            end
            default:
            begin
                out_kind = shp_pkg::KIND_ERR;
            end
        endcase
    end

    assign out_valid = valid_reg;
    assign out_last  = last_beat;

endmodule

// ===== design/socks5_server_handshake_parser.sv =====
// SOCKS5 server handshake parser, top level. Depends on shp_pkg, shp_parser, shp_emitter.
// Throughput: one client byte per cycle; a byte that yields results occupies the output
//   for as many beats as it yields (1, 2 or 10), the output port being the only limit.
// Path: a byte's results pass the parser's result register, then the emitter's burst register.
// Reset (rst_n, async, active low): parser back at the greeting, no beats pending,
//   nibble swap off.
module socks5_server_handshake_parser (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration: the single swap_enable register
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,

    // Client bytes in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] new_session

    // Results out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [23:8] dest_port,
                                        // [25:24] error_code, rest zero
    output logic [2:0]  m_axis_tuser,   // [1:0] out_kind, [2] addr_kind
    output logic        m_axis_tlast    // last beat caused by one input beat
);

    // Swap enable; the user must write it only while the block is idle; nothing enforces it.
    logic swap_en_reg, swap_en_next;

    always_comb
    begin
        swap_en_next = cfg_wr_en ? cfg_wr_data : swap_en_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            swap_en_reg <= 1'b0;
        else
            swap_en_reg <= swap_en_next;
    end

    // Parser -> emitter: one burst descriptor held in the parser's result register.
    // The emitter can drain it while its own last beat leaves, so bytes keep flowing.
    logic                 pend_valid;
    shp_pkg::burst_desc_t pend_desc;
    logic                 load_ready;

    logic [1:0]           out_kind;
    logic [7:0]           out_byte;
    logic [15:0]          dest_port;
    logic                 addr_kind;
    logic [1:0]           error_code;

    shp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .swap_en     (swap_en_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .rx_byte     (s_axis_tdata),
        .new_session (s_axis_tuser),
        .load_ready  (load_ready),
        .pend_valid  (pend_valid),
        .pend_desc   (pend_desc)
    );

    // Emitter expands a burst: error (1 beat), greeting reply (2), address byte (1),
    // final reply with port (10).
    shp_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .swap_en    (swap_en_reg),
        .pend_valid (pend_valid),
        .pend_desc  (pend_desc),
        .load_ready (load_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_kind   (out_kind),
        .out_byte   (out_byte),
        .dest_port  (dest_port),
        .addr_kind  (addr_kind),
        .error_code (error_code),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, error_code, dest_port, out_byte};
    assign m_axis_tuser = {addr_kind, out_kind};

`ifndef SYNTH
    // A queued burst stays until the emitter takes it
    a_pend_held: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid && !load_ready |=> pend_valid)
        else $error("queued burst dropped");

    // A burst does not stop before its last beat
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("burst cut short");

    // An error is always a single, final beat
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] == shp_pkg::KIND_ERR) |-> m_axis_tlast)
        else $error("error beat not last");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for socks5_server_handshake_parser: greeting, request,
// address and final-reply beats checked against an in-bench parser model.
// Depends on shp_pkg (phase codes, kinds, error codes) and the design top level.
`timescale 1ns / 1ps

module testbench;

    // Pad after the last owed beat: results pass the parser and emitter registers, so a byte that
    // yields nothing may still be in flight when the queue runs empty.
    localparam int LATENCY_PAD  = 6;
    localparam int HOLD_CYCLES  = 300;      // long output back-pressure stretch
    localparam int PHASE_ITEMS  = 60;       // counted client bytes per random phase
    localparam int N_DIR_ROWS   = 25;
    // Fixed head of the final reply; port hi/lo follow it
    localparam logic [63:0] FINAL_HEAD = 64'h0500_0001_3445_F25E;

    // One output beat as the model expects it
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] port;
        logic        akind;
        logic [1:0]  err;
        logic        last;
    } beat_t;

    // Directed stimulus row; typed rows carry their single expected beat
    typedef struct packed {
        logic [7:0] rx;
        logic       ns;
        logic       typed;
        logic [1:0] kind;
        logic [1:0] err;
    } row_t;

    typedef enum int {
        S_IPV4     = 0,
        S_NAME     = 1,
        S_BAD_VER  = 2,
        S_BAD_ATYP = 3,
        S_ZERO_LEN = 4,
        S_JUNK     = 5
    } sess_kind_t;

    // ---------------------------------------------------------------- DUT I/O
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic        s_axis_tuser = 1'b0;    // [0] new_session
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [7:0] byte, [23:8] port, [25:24] error_code
    logic [2:0]  m_axis_tuser;           // [1:0] kind, [2] addr_kind
    logic        m_axis_tlast;

    socks5_server_handshake_parser uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------- parser model state
    shp_pkg::phase_t ph = shp_pkg::PH_GVER;
    logic [7:0]  left_cnt = 8'h00;      // methods / address bytes still to come
    logic [7:0]  greet_ver = 8'h00;
    logic        name_addr = 1'b0;      // 1 once ATYP picked a domain name
    logic [15:0] port_acc = 16'h0000;
    logic        swap_on = 1'b0;        // shadow of the swap register

    beat_t       burst_buf [10];        // beats caused by the byte just parsed
    int          burst_len = 0;
    beat_t       owed [$];              // beats still to come out of the block

    logic [7:0]  sess [$];              // logical bytes of the session being sent

    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          err_count = 0;
    int          beats_checked = 0;
    int          items_sent = 0;
    int          sessions_run = 0;
    int          sessions_cut = 0;

    logic        hold_req = 1'b0;       // toggled to ask for a long output stall
    logic        hold_seen = 1'b0;
    int          hold_left = 0;

    // Directed table. Swap is off here. Rows marked typed produce exactly one
    // error beat, readable straight from the protocol.
    row_t dir_rows [N_DIR_ROWS] = '{
        // bad greeting version straight after reset, NMETHODS 0 counts as one
        '{8'h04, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{8'hFF, 1'b0, 1'b1, shp_pkg::KIND_ERR,   shp_pkg::ERR_BAD_VER},
        // parser is done: this byte is dropped without a result
        '{8'h05, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        // good greeting, request header unchecked, IPv4 with extreme bytes
        '{8'h05, 1'b1, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{8'h01, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{shp_pkg::ATYP_IPV4, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{8'h7F, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{8'h80, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        // two methods, then an unsupported address type
        '{8'h05, 1'b1, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{8'h02, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{8'h80, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{8'h7F, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, shp_pkg::KIND_REPLY, shp_pkg::ERR_NONE},
        '{8'h02, 1'b0, 1'b1, shp_pkg::KIND_ERR,   shp_pkg::ERR_BAD_ATYP}
    };

    // ------------------------------------------------------------ the model
    function automatic logic [7:0] wire_view(input logic [7:0] b);
        return swap_on ? {b[3:0], b[7:4]} : b;
    endfunction

    function automatic void emit(input logic [1:0] kind, input logic [7:0] data,
                                 input logic [15:0] port, input logic akind,
                                 input logic [1:0] err);
        burst_buf[burst_len] = '{kind, data, port, akind, err, 1'b0};
        burst_len++;
    endfunction

    function automatic void session_reset();
        ph        = shp_pkg::PH_GVER;
        left_cnt  = 8'h00;
        greet_ver = 8'h00;
        name_addr = 1'b0;
        port_acc  = 16'h0000;
    endfunction

    // Advance the model by one client byte; fills burst_buf/burst_len
    function automatic void parse_byte(input logic [7:0] raw, input logic ns);
        logic [7:0] b;
        int         i;
        burst_len = 0;
        if (ns)
            session_reset();
        b = wire_view(raw);
        case (ph)
            shp_pkg::PH_GVER:
            begin
                greet_ver = b;
                ph = shp_pkg::PH_GNMETH;
            end
            shp_pkg::PH_GNMETH:
            begin
                left_cnt = (b == 8'h00) ? 8'd1 : b;
                ph = shp_pkg::PH_GMETH;
            end
            shp_pkg::PH_GMETH:
            begin
                left_cnt = left_cnt - 8'd1;
                if (left_cnt == 8'h00)
                begin
                    if (greet_ver != shp_pkg::SOCKS_VER)
                    begin
                        emit(shp_pkg::KIND_ERR, 8'h00, 16'h0000, 1'b0, shp_pkg::ERR_BAD_VER);
                        ph = shp_pkg::PH_DONE;
                    end
                    else
                    begin
                        emit(shp_pkg::KIND_REPLY, wire_view(shp_pkg::SOCKS_VER), 16'h0000,
                             1'b0, shp_pkg::ERR_NONE);
                        emit(shp_pkg::KIND_REPLY, wire_view(8'h00), 16'h0000, 1'b0,
                             shp_pkg::ERR_NONE);
                        ph = shp_pkg::PH_RVER;
                    end
                end
            end
            shp_pkg::PH_RVER: ph = shp_pkg::PH_RCMD;
            shp_pkg::PH_RCMD: ph = shp_pkg::PH_RRSV;
            shp_pkg::PH_RRSV: ph = shp_pkg::PH_RATYP;
            shp_pkg::PH_RATYP:
            begin
                if (b == shp_pkg::ATYP_IPV4)
                begin
                    name_addr = 1'b0;
                    left_cnt = shp_pkg::IPV4_BYTES;
                    ph = shp_pkg::PH_RADDR;
                end
                else if (b == shp_pkg::ATYP_NAME)
                begin
                    name_addr = 1'b1;
                    ph = shp_pkg::PH_RLEN;
                end
                else
                begin
                    emit(shp_pkg::KIND_ERR, 8'h00, 16'h0000, 1'b0, shp_pkg::ERR_BAD_ATYP);
                    ph = shp_pkg::PH_DONE;
                end
            end
            shp_pkg::PH_RLEN:
            begin
                if (b == 8'h00)
                begin
                    emit(shp_pkg::KIND_ERR, 8'h00, 16'h0000, 1'b0, shp_pkg::ERR_ZERO_NAME);
                    ph = shp_pkg::PH_DONE;
                end
                else
                begin
                    left_cnt = b;
                    ph = shp_pkg::PH_RADDR;
                end
            end
            shp_pkg::PH_RADDR:
            begin
                emit(shp_pkg::KIND_ADDR, b, 16'h0000, name_addr, shp_pkg::ERR_NONE);
                left_cnt = left_cnt - 8'd1;
                if (left_cnt == 8'h00)
                    ph = shp_pkg::PH_PHI;
            end
            shp_pkg::PH_PHI:
            begin
                port_acc = {b, 8'h00};
                ph = shp_pkg::PH_PLO;
            end
            shp_pkg::PH_PLO:
            begin
                port_acc[7:0] = b;
                for (i = 0; i < 8; i++)
                    emit(shp_pkg::KIND_REPLY, wire_view(FINAL_HEAD[63 - 8 * i -: 8]), port_acc,
                         name_addr, shp_pkg::ERR_NONE);
                emit(shp_pkg::KIND_REPLY, wire_view(port_acc[15:8]), port_acc, name_addr,
                     shp_pkg::ERR_NONE);
                emit(shp_pkg::KIND_REPLY, wire_view(port_acc[7:0]), port_acc, name_addr,
                     shp_pkg::ERR_NONE);
                ph = shp_pkg::PH_DONE;
            end
            default: ph = shp_pkg::PH_DONE;
        endcase
        if (burst_len > 0)
            burst_buf[burst_len - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------- checking
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Output beats are sampled at the rising edge and matched in order
    always @(posedge clk)
    begin : out_check
        beat_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beats_checked++;
            if (owed.size() == 0)
                report_mismatch("beat with nothing owed", m_axis_tdata, 32'h0);
            else
            begin
                w = owed.pop_front();
                if (m_axis_tuser[1:0] != w.kind)
                    report_mismatch("out_kind", m_axis_tuser[1:0], w.kind);
                if (m_axis_tdata[7:0] != w.data)
                    report_mismatch("out_byte", m_axis_tdata[7:0], w.data);
                if (m_axis_tdata[23:8] != w.port)
                    report_mismatch("dest_port", m_axis_tdata[23:8], w.port);
                if (m_axis_tuser[2] != w.akind)
                    report_mismatch("addr_kind", m_axis_tuser[2], w.akind);
                if (m_axis_tdata[25:24] != w.err)
                    report_mismatch("error_code", m_axis_tdata[25:24], w.err);
                if (m_axis_tdata[31:26] != 6'b000000)
                    report_mismatch("tdata pad bits", m_axis_tdata[31:26], 32'h0);
                if (m_axis_tlast != w.last)
                    report_mismatch("tlast", m_axis_tlast, w.last);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request. The hold
    // is counted here so the sender keeps offering bytes meanwhile.
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // ------------------------------------------------------------- driving
    // Offer one byte from a falling edge; model it at the accepting edge.
    // tvalid stays high between back-to-back bytes (no low/high in one step).
    task automatic push_byte(input logic [7:0] raw, input logic ns, input logic typed,
                             input beat_t want);
        int k;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        s_axis_tuser  <= ns;
        do
            @(posedge clk);
        while (!s_axis_tready);
        parse_byte(raw, ns);
        if (typed)
            owed.push_back(want);
        else
            for (k = 0; k < burst_len; k++)
                owed.push_back(burst_buf[k]);
        items_sent++;
        @(negedge clk);
    endtask

    // Sender stops and waits for every owed beat, then the latency pad
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (owed.size() != 0)
            @(negedge clk);
        repeat (LATENCY_PAD) @(negedge clk);
    endtask

    // Only called with the block idle
    task automatic write_swap(input logic v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        swap_on = v;
    endtask

    // Random byte leaning toward the extremes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Logical (unswapped) bytes of one session into sess; big selects 255
    // methods and, for a name, a 255-byte name
    function automatic void build_session(input sess_kind_t sk, input logic big);
        int         n;
        logic [7:0] v;
        sess.delete();
        if (sk == S_JUNK)
        begin
            repeat ($urandom_range(1, 12)) sess.push_back(pick_byte());
            return;
        end
        if (sk == S_BAD_VER)
        begin
            do
                v = pick_byte();
            while (v == shp_pkg::SOCKS_VER);
        end
        else
            v = shp_pkg::SOCKS_VER;
        sess.push_back(v);
        v = big ? 8'hFF : 8'($urandom_range(0, 3));
        sess.push_back(v);
        n = (v == 8'h00) ? 1 : int'(v);
        repeat (n) sess.push_back(pick_byte());
        if (sk == S_BAD_VER)
            return;
        repeat (3) sess.push_back(pick_byte());     // VER CMD RSV, not checked
        case (sk)
            S_IPV4:
            begin
                sess.push_back(shp_pkg::ATYP_IPV4);
                repeat (4) sess.push_back(pick_byte());
            end
            S_BAD_ATYP:
            begin
                do
                    v = pick_byte();
                while (v == shp_pkg::ATYP_IPV4 || v == shp_pkg::ATYP_NAME);
                sess.push_back(v);
                return;
            end
            default:
            begin
                sess.push_back(shp_pkg::ATYP_NAME);
                if (sk == S_ZERO_LEN)
                begin
                    sess.push_back(8'h00);
                    return;
                end
                n = big ? 255 : $urandom_range(1, 6);
                sess.push_back(8'(n));
                repeat (n) sess.push_back(pick_byte());
            end
        endcase
        repeat (2) sess.push_back(pick_byte());     // port, high byte first
    endfunction

    // Send one session, possibly cut short; new_session only on its first
    // byte. Trailing noise after a finished session is not counted.
    task automatic run_session(input sess_kind_t sk, input logic big, input logic cut,
                               output int n_sent);
        int len;
        int i;
        build_session(sk, big);
        len = sess.size();
        if (cut && len > 1)
        begin
            len = $urandom_range(1, len - 1);
            sessions_cut++;
        end
        for (i = 0; i < len; i++)
            push_byte(wire_view(sess[i]), i == 0, 1'b0, '0);
        n_sent = len;
        sessions_run++;
        if (!cut && sk != S_JUNK && $urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) push_byte(pick_byte(), 1'b0, 1'b0, '0);
    endtask

    // One random phase: idle mix and swap setting fixed, first sessions walk
    // through every kind, then weighted picks favoring well-formed ones
    task automatic run_phase(input int tx_pct, input int rx_pct, input logic swap,
                             input logic squeeze);
        int         got;
        int         n;
        int         idx;
        int         r;
        sess_kind_t sk;
        got = 0;
        idx = 0;
        settle();
        write_swap(swap);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        if (squeeze)
        begin
            // output held off while a session streams in: input must stall
            hold_req <= ~hold_req;
            run_session(S_NAME, 1'b0, 1'b0, n);
            got += n;
        end
        while (got < PHASE_ITEMS)
        begin
            if (idx < 6)
                sk = sess_kind_t'(idx);
            else
            begin
                r = $urandom_range(99);
                if (r < 35)      sk = S_IPV4;
                else if (r < 70) sk = S_NAME;
                else if (r < 77) sk = S_BAD_VER;
                else if (r < 84) sk = S_BAD_ATYP;
                else if (r < 91) sk = S_ZERO_LEN;
                else             sk = S_JUNK;
            end
            run_session(sk, 1'b0, $urandom_range(7) == 0, n);
            got += n;
            idx++;
        end
    endtask

    // ------------------------------------------------------------ sequence
    initial
    begin
        int    r;
        beat_t want;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_swap(1'b0);

        tx_idle_pct  = 6;
        rx_stall_pct = 79;
        for (r = 0; r < N_DIR_ROWS; r++)
        begin
            want = '{dir_rows[r].kind, 8'h00, 16'h0000, 1'b0, dir_rows[r].err, 1'b1};
            push_byte(dir_rows[r].rx, dir_rows[r].ns, dir_rows[r].typed, want);
        end

        run_phase(6, 79, 1'b1, 1'b0);
        run_phase(79, 6, 1'b0, 1'b0);
        run_phase(0, 0, 1'b1, 1'b1);
        settle();

        if (owed.size() != 0)
            report_mismatch("beats never produced", 32'h0, owed.size());
        $display("summary: %0d client bytes in %0d random sessions (%0d cut short), %0d beats",
                 items_sent, sessions_run, sessions_cut, beats_checked);
        $display("summary: swap off and on, every error kind, a %0d-cycle output stall",
                 HOLD_CYCLES);
        if (err_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("timeout: %0d beats still owed", owed.size());
        $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== socks5_server_handshake_parser.f =====
design/shp_pkg.sv
design/shp_parser.sv
design/shp_emitter.sv
design/socks5_server_handshake_parser.sv
test/testbench.sv
